### rtl/lmsanc_pkg.sv
`timescale 1ns / 1ps

package lmsanc_pkg;

  // Default configuration of the filter.
  localparam int TAPS_DEF = 128;
  localparam int WFB_DEF  = 24;

  // Fixed field and datapath widths.
  localparam int SAMPLE_W       = 16;
  localparam int WEIGHT_W       = 32;
  localparam int STEP_W         = 24;
  localparam int STEP_FRAC_BITS = 24;
  localparam int K_W            = STEP_W + SAMPLE_W;   // step times error magnitude
  localparam int MUL_A_W        = K_W + 1;
  localparam int MUL_B_W        = SAMPLE_W + 1;
  localparam int PROD_W         = MUL_A_W + MUL_B_W;
  localparam int DELTA_W        = 64;                  // rescaled update magnitude
  localparam int NW_W           = DELTA_W + 1;         // weight plus signed update

  localparam logic [STEP_W-1:0] STEP_RESET = 24'd167772;

  // Operand selection of the shared multiplier.
  localparam logic [1:0] MUL_FIR  = 2'd0;   // weight times delayed reference
  localparam logic [1:0] MUL_UPD  = 2'd1;   // gain times reference magnitude
  localparam logic [1:0] MUL_STEP = 2'd2;   // step size times error magnitude

  // Magnitude of a signed sample; the most negative value maps to 2^15.
  function automatic logic [SAMPLE_W-1:0] mag16(input logic signed [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W:0] ext;
    logic signed [SAMPLE_W:0] neg;
    ext = (SAMPLE_W+1)'(v);
    neg = -ext;
    return v[SAMPLE_W-1] ? neg[SAMPLE_W-1:0] : ext[SAMPLE_W-1:0];
  endfunction

endpackage

### rtl/lmsanc_if.sv
`timescale 1ns / 1ps

// Input channel: one reference sample and one noisy sample per item.
interface lmsanc_in_if import lmsanc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] reference_sample;
  logic signed [SAMPLE_W-1:0] noisy_sample;
  logic                       stream_end;

  modport source (output valid, output reference_sample, output noisy_sample,
                  output stream_end, input ready);
  modport sink   (input valid, input reference_sample, input noisy_sample,
                  input stream_end, output ready);
endinterface

// Result channel: one clean sample per item.
interface lmsanc_out_if import lmsanc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] clean_sample;

  modport source (output valid, output clean_sample, input ready);
  modport sink   (input valid, input clean_sample, output ready);
endinterface

// Configuration write channel for the step size.
interface lmsanc_cfg_if import lmsanc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step_size;

  modport source (output valid, output step_size, input ready);
  modport sink   (input valid, input step_size, output ready);
endinterface

### rtl/lmsanc_mul.sv
`timescale 1ns / 1ps

// Shared multiplier with a registered product. The operand pair is chosen by op.
module lmsanc_mul import lmsanc_pkg::*; (
  input  logic                       clk,
  input  logic [1:0]                 op,
  input  logic signed [WEIGHT_W-1:0] weight,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [K_W-1:0]             gain,
  input  logic [STEP_W-1:0]          step,
  input  logic [SAMPLE_W-1:0]        err_mag,
  output logic signed [PROD_W-1:0]   prod_r
);

  logic signed [MUL_A_W-1:0] opa;
  logic signed [MUL_B_W-1:0] opb;
  logic signed [PROD_W-1:0]  prod_nxt;

  always_comb begin
    case (op)
      MUL_FIR: begin
        opa = MUL_A_W'(weight);
        opb = MUL_B_W'(sample);
      end
      MUL_UPD: begin
        opa = $signed({1'b0, gain});
        opb = $signed({1'b0, mag16(sample)});
      end
      MUL_STEP: begin
        opa = $signed(MUL_A_W'(step));
        opb = $signed({1'b0, err_mag});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_nxt = opa * opb;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

### rtl/lms_adaptive_noise_canceller_core.sv
`timescale 1ns / 1ps
// A producing item runs the filter pass, its drain and the estimate state, and its clean sample is
// shown when the error state hands it over. The input stays closed until the update pass has
// drained, since the one multiplier serves all taps and updates.
// A warm-up item that produces no result leaves the block idle and ready for the next item.
// Reset (rst_n low, synchronous) clears control state and then runs a pass that zeroes the
// weight memory; no item is accepted during that pass.
module lms_adaptive_noise_canceller_core import lmsanc_pkg::*; #(
  parameter int TAPS                 = TAPS_DEF,
  parameter int WEIGHT_FRACTION_BITS = WFB_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lmsanc_in_if.sink   in_ch,
  lmsanc_out_if.source out_ch,
  lmsanc_cfg_if.sink  cfg_ch
);

  localparam int AW    = $clog2(TAPS);
  // Sum of TAPS products of a 32-bit weight and a 16-bit sample never overflows this.
  localparam int ACC_W = WEIGHT_W + SAMPLE_W + AW;
  // Alignment of the Q.24 weight update to the weight format.
  localparam int SH    = WEIGHT_FRACTION_BITS - STEP_FRAC_BITS;
  localparam int LSH   = (SH > 0) ? SH : 0;
  localparam int RSH   = (SH < 0) ? -SH : 0;

  localparam logic [AW-1:0] LAST_IDX = AW'(TAPS - 1);

  localparam logic signed [ACC_W-1:0] EST_BIAS =
    ACC_W'((64'd1 << WEIGHT_FRACTION_BITS) - 64'd1);
  localparam logic signed [ACC_W:0]   DIFF_MAX = (ACC_W+1)'(32767);
  localparam logic signed [ACC_W:0]   DIFF_MIN = -(ACC_W+1)'(32768);
  localparam logic signed [NW_W-1:0]  NW_MAX   = NW_W'(33'sh0_7FFF_FFFF);
  localparam logic signed [NW_W-1:0]  NW_MIN   = -NW_W'(33'sh0_8000_0000);

  // Sequencer states.
  localparam logic [3:0] ST_CLR   = 4'd0;   // zero the weight memory after reset
  localparam logic [3:0] ST_IDLE  = 4'd1;   // ready for the next item
  localparam logic [3:0] ST_FILT  = 4'd2;   // issue one filter tap per cycle
  localparam logic [3:0] ST_FDRN  = 4'd3;   // let the last products reach the accumulator
  localparam logic [3:0] ST_EST   = 4'd4;   // scale the accumulator to a sample estimate
  localparam logic [3:0] ST_DIFF  = 4'd5;   // saturated error, hand it to the output
  localparam logic [3:0] ST_KMUL  = 4'd6;   // step size times error magnitude
  localparam logic [3:0] ST_KSAVE = 4'd7;   // keep that gain for the update pass
  localparam logic [3:0] ST_UPD   = 4'd8;   // issue one weight update per cycle
  localparam logic [3:0] ST_UDRN  = 4'd9;   // let the last updates be written

  logic [3:0]          state_r, state_nxt;
  logic [AW-1:0]       wa_r, wa_nxt;        // weight address, also the tap counter
  logic [AW-1:0]       ha_r, ha_nxt;        // history address of the same tap
  logic [AW-1:0]       wp_r, wp_nxt;        // history slot of the newest sample
  logic [AW-1:0]       fill_r, fill_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                s1_v_r, s2_v_r, s3_v_r;

  logic                in_acc;
  logic                issue;
  logic                flt_phase;
  logic                upd_phase;
  logic [AW-1:0]       wp_inc;
  logic [AW-1:0]       wa_inc;
  logic [AW-1:0]       ha_dec;
  logic [1:0]          mul_op;

  // The history and weight stores. The history is always fully written before it is
  // read, because a result needs TAPS samples of the current stream.
  logic signed [SAMPLE_W-1:0] hist_mem [TAPS];
  logic signed [WEIGHT_W-1:0] wt_mem   [TAPS];
  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [WEIGHT_W-1:0] wt_q;

  logic signed [SAMPLE_W-1:0] noisy_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_b;
  logic signed [ACC_W-1:0]    est_r;
  logic signed [ACC_W:0]      diff;
  logic signed [SAMPLE_W-1:0] err_sat;
  logic signed [SAMPLE_W-1:0] err_r;
  logic [SAMPLE_W-1:0]        emag;
  logic [K_W-1:0]             k_r;
  logic signed [PROD_W-1:0]   prod_r;

  logic [AW-1:0]              wa_s1_r, wa_s2_r, wa_s3_r;
  logic signed [WEIGHT_W-1:0] wt_s2_r, wt_s3_r;
  logic                       neg_s2_r;
  logic [DELTA_W-1:0]         mag64;
  logic [DELTA_W-1:0]         smag;
  logic signed [NW_W-1:0]     dlt;
  logic signed [NW_W-1:0]     d_r;
  logic signed [NW_W-1:0]     nw;
  logic signed [WEIGHT_W-1:0] nw_sat;

  logic                       wt_we;
  logic [AW-1:0]              wt_waddr;
  logic signed [WEIGHT_W-1:0] wt_wdata;

  // Handshakes. Configuration is taken in any cycle.
  assign in_ch.ready         = (state_r == ST_IDLE);
  assign in_acc              = in_ch.valid && (state_r == ST_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.clean_sample = err_r;

  assign wp_inc = (wp_r == LAST_IDX) ? '0 : wp_r + AW'(1);
  assign wa_inc = (wa_r == LAST_IDX) ? '0 : wa_r + AW'(1);
  assign ha_dec = (ha_r == '0) ? LAST_IDX : ha_r - AW'(1);

  assign issue     = (state_r == ST_FILT) || (state_r == ST_UPD);
  assign flt_phase = (state_r == ST_FILT) || (state_r == ST_FDRN);
  assign upd_phase = (state_r == ST_UPD) || (state_r == ST_UDRN);

  always_comb begin
    state_nxt     = state_r;
    wa_nxt        = wa_r;
    ha_nxt        = ha_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    step_nxt      = cfg_ch.valid ? cfg_ch.step_size : step_r;
    case (state_r)
      ST_CLR: begin
        wa_nxt = wa_inc;
        if (wa_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          wp_nxt = wp_inc;
          if (fill_r == LAST_IDX) begin
            // The line is full: this item produces a result.
            state_nxt = ST_FILT;
            wa_nxt    = '0;
            ha_nxt    = wp_inc;
          end else begin
            fill_nxt = fill_r + AW'(1);
          end
          // The end of a recording restarts warm-up but keeps weights and history.
          if (in_ch.stream_end) begin
            fill_nxt = '0;
          end
        end
      end
      ST_FILT: begin
        wa_nxt = wa_inc;
        ha_nxt = ha_dec;
        if (wa_r == LAST_IDX) begin
          state_nxt = ST_FDRN;
        end
      end
      ST_FDRN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = ST_EST;
        end
      end
      ST_EST: begin
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        // A previous result that has not been taken holds this one back.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_KMUL;
        end
      end
      ST_KMUL: begin
        state_nxt = ST_KSAVE;
      end
      ST_KSAVE: begin
        state_nxt = ST_UPD;
        wa_nxt    = '0;
        ha_nxt    = wp_r;
      end
      ST_UPD: begin
        wa_nxt = wa_inc;
        ha_nxt = ha_dec;
        if (wa_r == LAST_IDX) begin
          state_nxt = ST_UDRN;
        end
      end
      ST_UDRN: begin
        if (!s1_v_r && !s2_v_r && !s3_v_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      wa_r        <= '0;
      ha_r        <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_RESET;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wa_r        <= wa_nxt;
      ha_r        <= ha_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r && upd_phase;
    end
  end

  // Multiplier operands follow the phase of the sequencer.
  always_comb begin
    if (state_r == ST_KMUL) begin
      mul_op = MUL_STEP;
    end else if (upd_phase) begin
      mul_op = MUL_UPD;
    end else begin
      mul_op = MUL_FIR;
    end
  end

  assign emag = mag16(err_r);

  lmsanc_mul u_mul (
    .clk     (clk),
    .op      (mul_op),
    .weight  (wt_q),
    .sample  (hist_q),
    .gain    (k_r),
    .step    (step_r),
    .err_mag (emag),
    .prod_r  (prod_r)
  );

  // Estimate: accumulator over 2^WFB, truncated toward zero by biasing negative sums.
  assign acc_b = acc_r + (acc_r[ACC_W-1] ? EST_BIAS : '0);

  // Error: noisy minus estimate, saturated to the sample range.
  assign diff = (ACC_W+1)'(noisy_r) - (ACC_W+1)'(est_r);
  always_comb begin
    if (diff > DIFF_MAX) begin
      err_sat = SAMPLE_W'(DIFF_MAX);
    end else if (diff < DIFF_MIN) begin
      err_sat = SAMPLE_W'(DIFF_MIN);
    end else begin
      err_sat = diff[SAMPLE_W-1:0];
    end
  end

  // Update magnitude step*|err|*|ref| is rescaled to the weight format; the right
  // shift of a magnitude truncates toward zero.
  assign mag64 = DELTA_W'($unsigned(prod_r));
  assign smag  = (mag64 << LSH) >> RSH;
  assign dlt   = neg_s2_r ? -$signed({1'b0, smag}) : $signed({1'b0, smag});

  assign nw = NW_W'(wt_s3_r) + d_r;
  always_comb begin
    if (nw > NW_MAX) begin
      nw_sat = WEIGHT_W'(NW_MAX);
    end else if (nw < NW_MIN) begin
      nw_sat = WEIGHT_W'(NW_MIN);
    end else begin
      nw_sat = nw[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      noisy_r <= in_ch.noisy_sample;
      acc_r   <= '0;
    end else if (s2_v_r && flt_phase) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (state_r == ST_EST) begin
      est_r <= acc_b >>> WEIGHT_FRACTION_BITS;
    end
    if (state_r == ST_DIFF && (!out_valid_r || out_ch.ready)) begin
      err_r <= err_sat;
    end
    if (state_r == ST_KSAVE) begin
      k_r <= prod_r[K_W-1:0];
    end
    wa_s1_r  <= wa_r;
    wa_s2_r  <= wa_s1_r;
    wt_s2_r  <= wt_q;
    neg_s2_r <= err_r[SAMPLE_W-1] ^ hist_q[SAMPLE_W-1];
    wa_s3_r  <= wa_s2_r;
    wt_s3_r  <= wt_s2_r;
    d_r      <= dlt;
  end

  // Weight store: the clearing pass after reset, then the updates of each item.
  assign wt_we    = (state_r == ST_CLR) || s3_v_r;
  assign wt_waddr = (state_r == ST_CLR) ? wa_r : wa_s3_r;
  assign wt_wdata = (state_r == ST_CLR) ? '0 : nw_sat;

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= wt_wdata;
    end
    wt_q <= wt_mem[wa_r];
  end

  // History store used as a circular delay line; tap i sits i slots behind the newest.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hist_mem[wp_inc] <= in_ch.reference_sample;
    end
    hist_q <= hist_mem[ha_r];
  end

endmodule

### rtl/lmsanc_chk.sv
`timescale 1ns / 1ps

module lmsanc_chk import lmsanc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] clean_sample
);

  // A result waiting at the output holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(clean_sample))
    else $error("result changed or dropped while stalled");

  // A result appears while its item is still being worked on.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_ready)
    else $error("result appeared while the block was ready");

  // No result can follow an accepted item in the very next cycle.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result came one cycle after an item");

  // The clearing pass keeps the input closed right after reset.
  a_clear_pass: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("item accepted before the weight memory was cleared");

endmodule

bind lms_adaptive_noise_canceller_core lmsanc_chk u_lmsanc_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .clean_sample (out_ch.clean_sample)
);

### dv/lmsanc_clean_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the noise canceller, keeps its own copy of the
// delay line, the tap weights and the step size, and compares every clean
// sample that leaves the block with the value predicted for it.
module lmsanc_clean_checker import lmsanc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  lmsanc_in_if  in_mon,
  lmsanc_out_if out_mon,
  lmsanc_cfg_if cfg_mon,
  output int    fail_count,
  output int    pending_count,
  output int    checked_count
);

  localparam int TAPS    = TAPS_DEF;
  localparam int WFB     = WFB_DEF;
  localparam int RESCALE = WFB - STEP_FRAC_BITS;
  localparam int UP      = (RESCALE > 0) ? RESCALE : 0;
  localparam int DOWN    = (RESCALE < 0) ? -RESCALE : 0;

  localparam logic signed [63:0] WEIGHT_HI = 64'sd2147483647;
  localparam logic signed [63:0] WEIGHT_LO = -64'sd2147483648;
  localparam logic signed [63:0] PCM_HI    = 64'sd32767;
  localparam logic signed [63:0] PCM_LO    = -64'sd32768;

  logic signed [SAMPLE_W-1:0] ref_line [TAPS];
  logic signed [WEIGHT_W-1:0] weights [TAPS];
  int unsigned                fill_level;
  logic [STEP_W-1:0]          step_now;
  logic signed [SAMPLE_W-1:0] clean_due [$];

  int fails   = 0;
  int checked = 0;

  assign fail_count    = fails;
  assign checked_count = checked;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] clean sample mismatch: %s, got %0d, expected %0d", $time, what, got,
             want);
    fails++;
  endtask

  // Filter estimate: divide by 2^WFB with truncation toward zero.
  function automatic logic signed [63:0] scale_down(input logic signed [63:0] acc);
    if (acc >= 0) return acc >>> WFB;
    return -((-acc) >>> WFB);
  endfunction

  // One accepted item: shift the delay line, and once it is full filter,
  // queue the clean sample and adapt every weight with the new error.
  function automatic void absorb_sample(input logic signed [SAMPLE_W-1:0] r_in,
                                        input logic signed [SAMPLE_W-1:0] n_in,
                                        input logic last);
    logic signed [63:0]         acc;
    logic signed [63:0]         wx;
    logic signed [63:0]         rx;
    logic signed [63:0]         diff;
    logic signed [63:0]         err64;
    logic signed [63:0]         delta;
    logic signed [63:0]         nw;
    logic [63:0]                emag;
    logic [63:0]                rmag;
    logic [63:0]                mag;
    logic signed [SAMPLE_W-1:0] err;
    for (int i = TAPS - 1; i > 0; i--) ref_line[i] = ref_line[i-1];
    ref_line[0] = r_in;
    if (fill_level < TAPS - 1) begin
      fill_level++;
    end else begin
      acc = 0;
      for (int i = 0; i < TAPS; i++) begin
        wx = weights[i];
        rx = ref_line[i];
        acc += wx * rx;
      end
      rx = n_in;
      diff = rx - scale_down(acc);
      if (diff > PCM_HI) diff = PCM_HI;
      if (diff < PCM_LO) diff = PCM_LO;
      err = diff[SAMPLE_W-1:0];
      clean_due.push_back(err);
      err64 = err;
      emag = (err64 < 0) ? -err64 : err64;
      for (int i = 0; i < TAPS; i++) begin
        rx = ref_line[i];
        rmag = (rx < 0) ? -rx : rx;
        mag = 64'(step_now) * emag * rmag;
        mag = (mag << UP) >> DOWN;
        delta = ((err64 < 0) != (rx < 0)) ? -$signed(mag) : $signed(mag);
        wx = weights[i];
        nw = wx + delta;
        if (nw > WEIGHT_HI) nw = WEIGHT_HI;
        if (nw < WEIGHT_LO) nw = WEIGHT_LO;
        weights[i] = nw[WEIGHT_W-1:0];
      end
    end
    if (last) fill_level = 0;
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        ref_line[i] = '0;
        weights[i]  = '0;
      end
      fill_level = 0;
      step_now   = STEP_RESET;
      clean_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) step_now = cfg_mon.step_size;
      if (out_mon.valid && out_mon.ready) begin
        if (clean_due.size() == 0) begin
          report_mismatch("no item pending", int'(out_mon.clean_sample), 0);
        end else begin
          want = clean_due.pop_front();
          if (out_mon.clean_sample !== want) begin
            report_mismatch("wrong value", int'(out_mon.clean_sample), int'(want));
          end
          checked++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        absorb_sample(in_mon.reference_sample, in_mon.noisy_sample, in_mon.stream_end);
      end
    end
    pending_count <= clean_due.size();
  end

  final begin
    if (clean_due.size() != 0) begin
      $display("%0d clean samples never arrived", clean_due.size());
    end
  end

endmodule

### dv/lms_adaptive_noise_canceller_core_test.sv
`timescale 1ns / 1ps

module lms_adaptive_noise_canceller_core_test;
  import lmsanc_pkg::*;

  localparam int TAPS             = TAPS_DEF;
  // The weight updates of a producing item run on after its clean sample has left,
  // so the drain waits out this margin before the block counts as idle.
  localparam int SETTLE_CYCLES    = 2 * TAPS + 24;
  localparam int LONG_HOLD_CYCLES = 4000;
  localparam int ITEM_BUDGET      = 1550;
  localparam logic [STEP_W-1:0] STEP_MAX = '1;
  localparam logic [STEP_W-1:0] STEP_OFF = '0;

  // Flavors of sample content for one stream.
  typedef enum int {
    SIG_FULL,    // uniform over the whole 16-bit range
    SIG_QUIET,   // small amplitudes, so the weights can adapt without saturating
    SIG_ECHO,    // noisy input follows the reference, as in a real canceller
    SIG_EXTREME  // only the corner values of the PCM range
  } sig_mode_e;

  // Patterns of the result receiver.
  typedef enum int {
    RX_ALWAYS,
    RX_HALF,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic clk;
  logic rst_n;

  lmsanc_in_if  in_if ();
  lmsanc_out_if out_if ();
  lmsanc_cfg_if cfg_if ();

  int fail_count;
  int pending_count;
  int checked_count;

  int items_sent    = 0;
  int step_writes   = 0;
  int burst_left    = 0;
  bit sender_steady = 1'b0;
  bit hold_request  = 1'b0;

  lms_adaptive_noise_canceller_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  lmsanc_clean_checker clean_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_mon       (cfg_if),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver switches between ready patterns, holding each for a random stretch.
  // When the stimulus asks for a long hold, it keeps ready low for LONG_HOLD_CYCLES,
  // which it counts itself, so the block backs up into its input.
  initial begin : receiver
    rx_mode_e rx_mode;
    int       mode_left;
    int       tick;
    logic     take;
    out_if.ready = 1'b0;
    rx_mode      = RX_ALWAYS;
    mode_left    = 0;
    tick         = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 600);
        end
        mode_left--;
        tick++;
        case (rx_mode)
          RX_ALWAYS:   take = 1'b1;
          RX_HALF:     take = 1'($urandom_range(0, 1));
          RX_SPARSE:   take = ($urandom_range(0, 7) == 0);
          RX_PERIODIC: take = ((tick % 5) < 2);
          default:     take = 1'b1;
        endcase
        out_if.ready <= take;
      end
    end
  end

  // The corner values of a signed 16-bit sample.
  function automatic logic signed [SAMPLE_W-1:0] extreme_value(input int k);
    case (k % 5)
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'sh0001;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(input sig_mode_e mode);
    case (mode)
      SIG_QUIET:   return 16'(int'($urandom_range(0, 127)) - 64);
      SIG_EXTREME: return extreme_value($urandom_range(0, 4));
      default:     return 16'($urandom);
    endcase
  endfunction

  // Offers one item and returns after it was taken. Items go out
  // in bursts; at the end of a burst the sender may fall silent for a while.
  // Valid stays high between items of a burst, so the caller must offer the
  // next item or go idle before any time passes.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] r_smp,
                             input logic signed [SAMPLE_W-1:0] n_smp,
                             input logic last);
    int gap;
    in_if.valid            <= 1'b1;
    in_if.reference_sample <= r_smp;
    in_if.noisy_sample     <= n_smp;
    in_if.stream_end       <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering items and waits until every predicted clean sample has
  // come out, then lets the last weight update finish.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The step size only changes while the block is idle.
  task automatic write_step(input logic [STEP_W-1:0] value);
    wait_drained();
    cfg_if.valid     <= 1'b1;
    cfg_if.step_size <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    step_writes++;
  endtask

  // A well-formed stream: TAPS-1 warm-up items, then items that each give a
  // clean sample. With close set, the last item carries the stream end.
  task automatic run_stream(input int producing, input sig_mode_e mode, input bit close);
    int                         total;
    logic signed [SAMPLE_W-1:0] r_smp;
    logic signed [SAMPLE_W-1:0] n_smp;
    logic signed [SAMPLE_W-1:0] r_prev;
    total  = TAPS - 1 + producing;
    r_prev = '0;
    for (int k = 0; k < total; k++) begin
      r_smp = draw_sample(mode);
      if (mode == SIG_ECHO) begin
        n_smp = 16'((int'(r_prev) >>> 1) + int'($urandom_range(0, 63)) - 32);
      end else begin
        n_smp = draw_sample(mode);
      end
      push_sample(r_smp, n_smp, close && (k == total - 1));
      r_prev = r_smp;
    end
  endtask

  initial begin : stimulus
    int        phase;
    int        streams;
    int        n;
    sig_mode_e mode;

    // Every input is known from time zero, while reset is held low.
    rst_n                  = 1'b0;
    in_if.valid            = 1'b0;
    in_if.reference_sample = '0;
    in_if.noisy_sample     = '0;
    in_if.stream_end       = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.step_size       = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, still at the reset step size. The warm-up cycles through
    // the corner values, and then every pairing of corner reference and corner
    // noisy sample produces a result. The last of them ends the stream, so the
    // weights and the delay line are kept while warm-up starts over.
    for (int k = 0; k < TAPS - 1; k++) begin
      push_sample(extreme_value(k), extreme_value(k + 2), 1'b0);
    end
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        push_sample(extreme_value(i), extreme_value(j), (i == 4) && (j == 4));
      end
    end

    // A stream that ends while still warming up must give nothing, and the
    // next stream has to warm up from scratch.
    for (int k = 0; k < 10; k++) push_sample(draw_sample(SIG_FULL), draw_sample(SIG_FULL),
                                             k == 9);
    run_stream(3, SIG_QUIET, 1'b1);

    // Largest step with full-scale corners: the weights hit their limits and
    // the estimate grows far past the PCM range, so the output saturates.
    write_step(STEP_MAX);
    run_stream(6, SIG_EXTREME, 1'b1);

    // A zero step freezes the weights; the smallest nonzero step barely moves them.
    write_step(STEP_OFF);
    run_stream(4, SIG_FULL, 1'b1);
    write_step(24'd1);
    run_stream(4, SIG_QUIET, 1'b1);

    // Random part: each phase may pick a new step size and then runs a few streams of
    // random length and content, mixed with short broken streams.
    phase = 0;
    while (items_sent < ITEM_BUDGET) begin
      phase++;
      if (phase == 1 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       write_step(STEP_OFF);
          1:       write_step(STEP_MAX);
          2:       write_step(STEP_RESET);
          3:       write_step(STEP_W'($urandom_range(1, 255)));
          4:       write_step(STEP_W'($urandom_range(256, 65535)));
          default: write_step(STEP_W'($urandom));
        endcase
      end
      sender_steady = ($urandom_range(0, 4) == 0);

      // In the first phase the receiver holds off for a long stretch while
      // items keep coming, so the block fills and stalls its input.
      if (phase == 1) hold_request = 1'b1;

      streams = $urandom_range(1, 3);
      for (int s = 0; s < streams && items_sent < ITEM_BUDGET; s++) begin
        if ($urandom_range(0, 5) == 0) begin
          // Broken stream: shorter than the warm-up, cut off by a stream end.
          n = $urandom_range(1, 40);
          for (int k = 0; k < n; k++) begin
            push_sample(draw_sample(SIG_FULL), draw_sample(SIG_FULL), k == n - 1);
          end
        end else begin
          mode = sig_mode_e'($urandom_range(0, 3));
          run_stream($urandom_range(1, 120), mode, $urandom_range(0, 4) != 0);
        end
        // In the first phase the sender also pauses until all results are in.
        if (phase == 1 && s == 0) wait_drained();
      end
    end

    wait_drained();
    $display("Ran %0d items through the canceller; %0d clean samples checked, %0d step writes.",
             items_sent, checked_count, step_writes);
    $display("Streams mixed full-scale, quiet, echo and corner content with early stream ends.");
    if (fail_count == 0) begin
      $display("lms_adaptive_noise_canceller_core_test OK");
    end else begin
      $display("lms_adaptive_noise_canceller_core_test NOT OK");
    end
    $finish;
  end

  // A correct run finishes well within this limit.
  initial begin : watchdog
    #40_000_000;
    $display("Timed out with %0d clean samples still pending.", pending_count);
    $display("lms_adaptive_noise_canceller_core_test NOT OK");
    $finish;
  end

endmodule
